FILE: design/ccpe_pkg.sv
`timescale 1ns / 1ps

package ccpe_pkg;

   localparam logic [7:0] TAG_UTF8                 = 8'd1;
   localparam logic [7:0] TAG_INTEGER              = 8'd3;
   localparam logic [7:0] TAG_FLOAT                = 8'd4;
   localparam logic [7:0] TAG_LONG                 = 8'd5;
   localparam logic [7:0] TAG_DOUBLE               = 8'd6;
   localparam logic [7:0] TAG_CLASS                = 8'd7;
   localparam logic [7:0] TAG_STRING               = 8'd8;
   localparam logic [7:0] TAG_FIELD_REF            = 8'd9;
   localparam logic [7:0] TAG_METHOD_REF           = 8'd10;
   localparam logic [7:0] TAG_INTERFACE_METHOD_REF = 8'd11;
   localparam logic [7:0] TAG_NAME_AND_TYPE        = 8'd12;
   localparam logic [7:0] TAG_METHOD_HANDLE        = 8'd15;
   localparam logic [7:0] TAG_METHOD_TYPE          = 8'd16;
   localparam logic [7:0] TAG_INVOKE_DYNAMIC       = 8'd18;
   localparam logic [7:0] TAG_END                  = 8'hFF;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_END     = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN = 2'd2;

   typedef enum logic [1:0] {
      PH_TAG    = 2'd0,
      PH_FIRST  = 2'd1,
      PH_SECOND = 2'd2,
      PH_TEXT   = 2'd3
   } phase_type;

   typedef struct packed {
      logic       known;
      logic [2:0] first_len;
      logic [2:0] second_len;
   } layout_type;

   typedef struct packed {
      logic [7:0]  entry_tag;
      logic [31:0] value_first;
      logic [31:0] value_second;
      logic [7:0]  text_byte;
      logic        is_text;
      logic        last;
      logic [1:0]  error_code;
   } result_type;

   function automatic layout_type tag_layout(input logic [7:0] tag);
      layout_type lay;
      lay = '{known: 1'b1, first_len: 3'd0, second_len: 3'd0};
      case (tag)
         TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: begin
            lay.first_len = 3'd2;
         end
         TAG_INTEGER, TAG_FLOAT: begin
            lay.first_len = 3'd4;
         end
         TAG_LONG, TAG_DOUBLE: begin
            lay.first_len  = 3'd4;
            lay.second_len = 3'd4;
         end
         TAG_FIELD_REF, TAG_METHOD_REF, TAG_INTERFACE_METHOD_REF,
         TAG_NAME_AND_TYPE, TAG_INVOKE_DYNAMIC: begin
            lay.first_len  = 3'd2;
            lay.second_len = 3'd2;
         end
         TAG_METHOD_HANDLE: begin
            lay.first_len  = 3'd1;
            lay.second_len = 3'd2;
         end
         default: begin
            lay.known = 1'b0;
         end
      endcase
      return lay;
   endfunction

endpackage

FILE: design/ccpe_parser.sv
`timescale 1ns / 1ps

module ccpe_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   output logic                res_valid,
   output ccpe_pkg::result_type res
);
   import ccpe_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  tag_held_ff, tag_held_in;
   logic [2:0]  count_ff, count_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [31:0] acc_first_ff, acc_first_in;
   logic [31:0] acc_second_ff, acc_second_in;
   logic [1:0]  fault_ff, fault_in;
   layout_type  lay_new;
   layout_type  lay_held;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TAG;
         tag_held_ff   <= '0;
         count_ff      <= '0;
         remaining_ff  <= '0;
         acc_first_ff  <= '0;
         acc_second_ff <= '0;
         fault_ff      <= ERR_NONE;
      end else begin
         phase_ff      <= phase_in;
         tag_held_ff   <= tag_held_in;
         count_ff      <= count_in;
         remaining_ff  <= remaining_in;
         acc_first_ff  <= acc_first_in;
         acc_second_ff <= acc_second_in;
         fault_ff      <= fault_in;
      end
   end

   always_comb begin
      lay_new       = tag_layout(data_byte);
      lay_held      = tag_layout(tag_held_ff);
      phase_in      = phase_ff;
      tag_held_in   = tag_held_ff;
      count_in      = count_ff;
      remaining_in  = remaining_ff;
      acc_first_in  = acc_first_ff;
      acc_second_in = acc_second_ff;
      fault_in      = fault_ff;
      res_valid     = 1'b0;
      res           = '0;
      res.entry_tag = tag_held_ff;
      if (take) begin
         if (fault_ff != ERR_NONE) begin
            res_valid      = 1'b1;
            res.last       = 1'b1;
            res.error_code = fault_ff;
         end else begin
            case (phase_ff)
               PH_TAG: begin
                  tag_held_in   = data_byte;
                  count_in      = '0;
                  acc_first_in  = '0;
                  acc_second_in = '0;
                  remaining_in  = '0;
                  if (!lay_new.known) begin
                     fault_in       = (data_byte == TAG_END) ? ERR_END : ERR_UNKNOWN;
                     res_valid      = 1'b1;
                     res.entry_tag  = data_byte;
                     res.last       = 1'b1;
                     res.error_code = fault_in;
                  end else begin
                     phase_in = PH_FIRST;
                  end
               end
               PH_FIRST: begin
                  acc_first_in = {acc_first_ff[23:0], data_byte};
                  count_in     = count_ff + 3'd1;
                  if (count_in >= lay_held.first_len) begin
                     count_in = '0;
                     if (tag_held_ff == TAG_UTF8) begin
                        remaining_in    = acc_first_in[15:0];
                        phase_in        = (remaining_in == '0) ? PH_TAG : PH_TEXT;
                        res_valid       = 1'b1;
                        res.value_first = acc_first_in;
                        res.last        = (remaining_in == '0);
                     end else if (lay_held.second_len == 3'd0) begin
                        phase_in        = PH_TAG;
                        res_valid       = 1'b1;
                        res.value_first = acc_first_in;
                        res.last        = 1'b1;
                     end else begin
                        phase_in = PH_SECOND;
                     end
                  end
               end
               PH_SECOND: begin
                  acc_second_in = {acc_second_ff[23:0], data_byte};
                  count_in      = count_ff + 3'd1;
                  if (count_in >= lay_held.second_len) begin
                     count_in         = '0;
                     phase_in         = PH_TAG;
                     res_valid        = 1'b1;
                     res.value_first  = acc_first_ff;
                     res.value_second = acc_second_in;
                     res.last         = 1'b1;
                  end
               end
               PH_TEXT: begin
                  if (remaining_ff != '0) begin
                     remaining_in    = remaining_ff - 16'd1;
                     if (remaining_in == '0) begin
                        phase_in = PH_TAG;
                     end
                     res_valid       = 1'b1;
                     res.value_first = acc_first_ff;
                     res.text_byte   = data_byte;
                     res.is_text     = 1'b1;
                     res.last        = (remaining_in == '0);
                  end else begin
                     phase_in = PH_TAG;
                  end
               end
               default: begin
                  phase_in = PH_TAG;
               end
            endcase
         end
      end
   end

endmodule

FILE: design/ccpe_out_buf.sv
`timescale 1ns / 1ps

module ccpe_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ccpe_pkg::result_type in_data,
   input  logic                 out_ready,
   output logic                 out_valid,
   output ccpe_pkg::result_type out_data,
   output logic                 skid_full
);
   import ccpe_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       main_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   always_comb begin
      main_free     = !main_valid_ff || out_ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = in_valid;
            skid_in       = in_data;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign skid_full = skid_valid_ff;

endmodule

FILE: design/class_constant_pool_entry_parser_top.sv
`timescale 1ns / 1ps

// Constant pool parser: takes one class file constant pool byte per cycle while
// req_ready is high and returns one result per completed entry, per UTF8 text
// byte and, once an end tag or unknown tag has been seen, per byte until reset.
// Each result is registered in the output buffer before it shows on rsp_; a
// two-entry output register lets bytes keep flowing while a result waits, so
// req_ready falls only when both output entries are held by a stalled consumer.
module class_constant_pool_entry_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_entry_tag,
   output logic [31:0] rsp_value_first,
   output logic [31:0] rsp_value_second,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_is_text,
   output logic        rsp_last,
   output logic [1:0]  rsp_error_code
);
   import ccpe_pkg::*;

   logic       take;
   logic       res_valid;
   result_type res;
   result_type out_data;
   logic       skid_full;

   assign req_ready = !skid_full;
   assign take      = req_valid && req_ready;

   ccpe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   ccpe_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .skid_full (skid_full)
   );

   assign rsp_entry_tag    = out_data.entry_tag;
   assign rsp_value_first  = out_data.value_first;
   assign rsp_value_second = out_data.value_second;
   assign rsp_text_byte    = out_data.text_byte;
   assign rsp_is_text      = out_data.is_text;
   assign rsp_last         = out_data.last;
   assign rsp_error_code   = out_data.error_code;

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("output skid entry held while the main entry is empty");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE) |-> (rsp_last && !rsp_is_text))
      else $error("error transaction not marked as last");

   a_text_is_utf8: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_text) |-> (rsp_entry_tag == TAG_UTF8 &&
                                      rsp_error_code == ERR_NONE))
      else $error("text transaction carries a non-UTF8 tag");

   a_fault_answers: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE && rsp_ready && !skid_full &&
       req_valid) |=> rsp_valid)
      else $error("byte after a fault produced no transaction");

endmodule
